[hdl/ufw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufw_pkg: shared types and codes of the weighted union-find unit
// Field widths of the request and result ports and the request kind codes.
// ----------------------------------------------------------------------------
package ufw_pkg;

  // field widths of the request and result ports
  localparam int ID_FW  = 10;
  localparam int CNT_FW = 11;
  localparam int REQ_FW = 2;

  typedef logic [REQ_FW-1:0] req_t;
  typedef logic [ID_FW-1:0]  id_t;
  typedef logic [CNT_FW-1:0] cnt_t;

  // request kinds; the unused code behaves as a find
  localparam req_t REQ_FIND  = 2'd0;
  localparam req_t REQ_UNION = 2'd1;
  localparam req_t REQ_CONN  = 2'd2;

endpackage

[hdl/union_find_weighted_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_weighted_unit: disjoint-set engine, union by size
// Find with path compression, union and connected query over one forest
// held in a single synchronous RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result shows on
// the out_ ports for exactly one cycle with out_valid, and the receiver
// cannot stall it. Requests run one at a time, walking the forest in one RAM
// with one read and one write port: each tree level is read on the way up,
// and each node below the root is written on the way back while the path is
// pointed at the root. A union or connected query runs two such finds back to
// back, the spare state S_BSTART between them taking the place of the first
// find's closing step, and a union that joins two sets adds the link step
// S_LINK. A request with an out-of-range id answers in the cycle after it is
// taken. After reset and after every write of num_records the RAM is cleared
// to singletons, one entry per cycle, over all MAX_NODES entries; busy stays
// high meanwhile, while cfg writes are still taken.
// ----------------------------------------------------------------------------
module union_find_weighted_unit #(
  parameter int MAX_NODES = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  // request
  input  logic           start,
  output logic           busy,
  input  ufw_pkg::req_t  in_req_type,
  input  ufw_pkg::id_t   in_node_a,
  input  ufw_pkg::id_t   in_node_b,
  // configuration
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  ufw_pkg::cnt_t  cfg_num_records,
  // result
  output logic           out_valid,
  output ufw_pkg::id_t   out_root_a,
  output ufw_pkg::id_t   out_root_b,
  output logic           out_same_set,
  output logic           out_merged,
  output ufw_pkg::cnt_t  out_set_size,
  output ufw_pkg::cnt_t  out_set_count,
  output logic           out_bad_id
);

  import ufw_pkg::*;

  localparam int ID_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int ENT_W = ID_W + 1;
  localparam int LIM   = (MAX_NODES > 2047) ? 2047 : MAX_NODES;
  localparam int NRST  = (MAX_NODES < 1024) ? MAX_NODES : 1024;
  localparam cnt_t LIM_V  = CNT_FW'(LIM);
  localparam cnt_t NRST_V = CNT_FW'(NRST);
  localparam logic [ID_W-1:0] LAST_IDX = ID_W'(MAX_NODES - 1);

  // controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_COMP   = 3'd3;
  localparam logic [2:0] S_BSTART = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;
  localparam logic [2:0] S_LINK   = 3'd6;

  // RAM entry: root flag on top; below it the parent at a node, size-1 at a root
  logic             ram_we;
  logic [ID_W-1:0]  ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ID_W-1:0]  ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  logic [2:0]      state_r, state_nxt;
  logic [ID_W-1:0] clr_r, clr_nxt;
  cnt_t            n_r, n_nxt;
  cnt_t            sets_r, sets_nxt;
  req_t            req_r, req_nxt;
  logic [ID_W-1:0] a_r, a_nxt;
  logic [ID_W-1:0] b_r, b_nxt;
  logic            sel_b_r, sel_b_nxt;
  logic [ID_W-1:0] cur_r, cur_nxt;
  logic [ID_W-1:0] ra_r, ra_nxt;
  logic [ID_W-1:0] rb_r, rb_nxt;
  logic [ID_W-1:0] sa_r, sa_nxt;
  logic [ID_W-1:0] sb_r, sb_nxt;

  logic  out_valid_r, out_valid_nxt;
  id_t   out_root_a_r, out_root_a_nxt;
  id_t   out_root_b_r, out_root_b_nxt;
  logic  out_same_r, out_same_nxt;
  logic  out_merged_r, out_merged_nxt;
  cnt_t  out_size_r, out_size_nxt;
  cnt_t  out_count_r, out_count_nxt;
  logic  out_bad_r, out_bad_nxt;

  logic            cfg_fire;
  logic            req_two;
  logic            in_two;
  logic            in_bad;
  logic            rd_root;
  logic [ID_W-1:0] rd_val;
  logic [ID_W-1:0] start_node;
  logic [ID_W-1:0] cur_root;
  logic            a_wins;
  logic [ID_W-1:0] winner;
  logic [ID_W-1:0] loser;
  logic [ID_W-1:0] sum_m1;
  logic [2:0]      find_done_state;
  cnt_t            cfg_n;

  ufw_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_NODES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshake and decode; a request offered at rest goes ahead of a cfg write
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = ((state_r == S_IDLE) && !start) || (state_r == S_CLEAR);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_n     = (cfg_num_records > LIM_V) ? LIM_V : cfg_num_records;

  assign req_two = (req_r inside {REQ_UNION, REQ_CONN});
  assign in_two  = (in_req_type inside {REQ_UNION, REQ_CONN});
  assign in_bad  = ({1'b0, in_node_a} >= n_r) || (in_two && ({1'b0, in_node_b} >= n_r));

  assign rd_root    = ram_rdata[ID_W];
  assign rd_val     = ram_rdata[ID_W-1:0];
  assign start_node = sel_b_r ? b_r : a_r;
  assign cur_root   = sel_b_r ? rb_r : ra_r;

  // larger set wins; on equal sizes the first root stays on top
  assign a_wins = !(sa_r < sb_r);
  assign winner = a_wins ? ra_r : rb_r;
  assign loser  = a_wins ? rb_r : ra_r;
  assign sum_m1 = sa_r + sb_r + ID_W'(1);

  // after a find: go for the second root or wrap up
  assign find_done_state = (!sel_b_r && req_two) ? S_BSTART : S_FIN;

  // sequence the walk, compression and link steps
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    n_nxt          = n_r;
    sets_nxt       = sets_r;
    req_nxt        = req_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    sel_b_nxt      = sel_b_r;
    cur_nxt        = cur_r;
    ra_nxt         = ra_r;
    rb_nxt         = rb_r;
    sa_nxt         = sa_r;
    sb_nxt         = sb_r;
    out_valid_nxt  = 1'b0;
    out_root_a_nxt = out_root_a_r;
    out_root_b_nxt = out_root_b_r;
    out_same_nxt   = out_same_r;
    out_merged_nxt = out_merged_r;
    out_size_nxt   = out_size_r;
    out_count_nxt  = out_count_r;
    out_bad_nxt    = out_bad_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_r;
    ram_wdata      = '0;
    ram_raddr      = cur_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_bad) begin
            // answer at once, leave the store alone
            out_valid_nxt  = 1'b1;
            out_root_a_nxt = '0;
            out_root_b_nxt = '0;
            out_same_nxt   = 1'b0;
            out_merged_nxt = 1'b0;
            out_size_nxt   = '0;
            out_count_nxt  = sets_r;
            out_bad_nxt    = 1'b1;
          end else begin
            req_nxt   = in_req_type;
            a_nxt     = ID_W'(in_node_a);
            b_nxt     = ID_W'(in_node_b);
            sel_b_nxt = 1'b0;
            cur_nxt   = ID_W'(in_node_a);
            ram_raddr = ID_W'(in_node_a);
            state_nxt = S_WALK;
          end
        end
      end

      S_CLEAR: begin
        // sweep every entry back to a singleton root
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = {1'b1, {ID_W{1'b0}}};
        clr_nxt   = clr_r + ID_W'(1);
        if (clr_r == LAST_IDX) begin
          clr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      S_WALK: begin
        if (rd_root) begin
          // root reached: hold it and its size
          if (sel_b_r) begin
            rb_nxt = cur_r;
            sb_nxt = rd_val;
          end else begin
            ra_nxt = cur_r;
            sa_nxt = rd_val;
          end
          if (cur_r == start_node) begin
            state_nxt = find_done_state;
          end else begin
            cur_nxt   = start_node;
            ram_raddr = start_node;
            state_nxt = S_COMP;
          end
        end else begin
          // advance one level up
          cur_nxt   = rd_val;
          ram_raddr = rd_val;
        end
      end

      S_COMP: begin
        // point this node at the root, move on to its old parent
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = {1'b0, cur_root};
        if (rd_val == cur_root) begin
          state_nxt = find_done_state;
        end else begin
          cur_nxt   = rd_val;
          ram_raddr = rd_val;
        end
      end

      S_BSTART: begin
        // a spare state keeps the first read of the second find clear of the last write
        sel_b_nxt = 1'b1;
        cur_nxt   = b_r;
        ram_raddr = b_r;
        state_nxt = S_WALK;
      end

      S_FIN: begin
        if ((req_r == REQ_UNION) && (ra_r != rb_r)) begin
          // winner root takes the combined size
          ram_we    = 1'b1;
          ram_waddr = winner;
          ram_wdata = {1'b1, sum_m1};
          state_nxt = S_LINK;
        end else begin
          out_valid_nxt  = 1'b1;
          out_root_a_nxt = ID_FW'(ra_r);
          out_root_b_nxt = req_two ? ID_FW'(rb_r) : '0;
          out_same_nxt   = req_two && (ra_r == rb_r);
          out_merged_nxt = 1'b0;
          out_size_nxt   = CNT_FW'(sa_r) + CNT_FW'(1);
          out_count_nxt  = sets_r;
          out_bad_nxt    = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      S_LINK: begin
        // hang the smaller tree under the winner, drop one set
        ram_we    = 1'b1;
        ram_waddr = loser;
        ram_wdata = {1'b0, winner};
        sets_nxt  = (sets_r != '0) ? (sets_r - CNT_FW'(1)) : sets_r;
        out_valid_nxt  = 1'b1;
        out_root_a_nxt = ID_FW'(ra_r);
        out_root_b_nxt = ID_FW'(rb_r);
        out_same_nxt   = 1'b0;
        out_merged_nxt = 1'b1;
        out_size_nxt   = CNT_FW'(sum_m1) + CNT_FW'(1);
        out_count_nxt  = sets_nxt;
        out_bad_nxt    = 1'b0;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a new element count restarts the clearing sweep
    if (cfg_fire) begin
      n_nxt     = cfg_n;
      sets_nxt  = cfg_n;
      clr_nxt   = '0;
      state_nxt = S_CLEAR;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      n_r         <= NRST_V;
      sets_r      <= NRST_V;
      sel_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      n_r         <= n_nxt;
      sets_r      <= sets_nxt;
      sel_b_r     <= sel_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    cur_r        <= cur_nxt;
    ra_r         <= ra_nxt;
    rb_r         <= rb_nxt;
    sa_r         <= sa_nxt;
    sb_r         <= sb_nxt;
    out_root_a_r <= out_root_a_nxt;
    out_root_b_r <= out_root_b_nxt;
    out_same_r   <= out_same_nxt;
    out_merged_r <= out_merged_nxt;
    out_size_r   <= out_size_nxt;
    out_count_r  <= out_count_nxt;
    out_bad_r    <= out_bad_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_root_a    = out_root_a_r;
  assign out_root_b    = out_root_b_r;
  assign out_same_set  = out_same_r;
  assign out_merged    = out_merged_r;
  assign out_set_size  = out_size_r;
  assign out_set_count = out_count_r;
  assign out_bad_id    = out_bad_r;

  // a result only shows once the controller is back at rest
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while a request is in flight");

  // every node on a compressed path must still be a non-root
  a_comp_nonroot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP) |-> (!rd_root && (cur_r != cur_root)))
    else $error("compression step reached a root entry");

  // the set count only falls, except on a new element count
  a_sets_mono: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_fire |=> (sets_r <= $past(sets_r)))
    else $error("set count rose without a configuration write");

  // a merge joins two distinct sets into one of at least two
  a_merge_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_merged_r) |-> (!out_same_r && !out_bad_r && (out_size_r >= CNT_FW'(2))))
    else $error("merge result inconsistent");

endmodule

[hdl/ufw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufw_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ufw_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write at one address, read another, data out on the next cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
